FILE: rtl/sbc_pkg.sv
// Shared types, constants and round functions for the SHA-256 block compressor.
`default_nettype none

package sbc_pkg;

    typedef logic [31:0] t_word;

    localparam int ROUNDS    = 64;
    localparam int BLK_WORDS = 16;
    localparam int HASH_WORDS = 8;

    localparam t_word K_ROUND [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam t_word H_INIT [HASH_WORDS] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic t_word rotr(input t_word v, input int unsigned n);
        rotr = (v >> n) | (v << (32 - n));
    endfunction

    function automatic t_word sig_small0(input t_word v);
        sig_small0 = rotr(v, 7) ^ rotr(v, 18) ^ (v >> 3);
    endfunction

    function automatic t_word sig_small1(input t_word v);
        sig_small1 = rotr(v, 17) ^ rotr(v, 19) ^ (v >> 10);
    endfunction

    function automatic t_word sig_big0(input t_word v);
        sig_big0 = rotr(v, 2) ^ rotr(v, 13) ^ rotr(v, 22);
    endfunction

    function automatic t_word sig_big1(input t_word v);
        sig_big1 = rotr(v, 6) ^ rotr(v, 11) ^ rotr(v, 25);
    endfunction

    function automatic t_word choose(input t_word e, input t_word f, input t_word g);
        choose = (e & f) ^ (~e & g);
    endfunction

    function automatic t_word majority(input t_word a, input t_word b, input t_word c);
        majority = (a & b) ^ (a & c) ^ (b & c);
    endfunction

endpackage

`default_nettype wire

FILE: rtl/sha256_block_compress.sv
// SHA-256 block compressor: word gather, iterative round unit and digest output.
`default_nettype none

// Takes a padded message as 32-bit big-endian words, sixteen per 512-bit block,
// over a valid/ready input channel. first_block and last_block are sampled only
// with the sixteenth word of a block: first_block reloads the standard initial
// hash before the block, last_block makes the block emit the eight digest words
// (index 0 most significant, digest_last on index 7) over the output channel.
// The sixteenth word starts the compression: one shared round unit runs one
// round per cycle for all 64 rounds, then state S_FINAL adds the working
// variables into the chaining value; the input is closed during the rounds and
// the chaining add. A final block then presents eight digest transactions, at
// best one per cycle; during that time the first fifteen words of the next
// block may already be taken, while the sixteenth waits until the last digest
// word has gone. The message schedule lives in a sixteen-word shift window,
// expanded one word per round alongside the round unit, so no schedule memory
// is needed.
module sha256_block_compress (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [31:0] i_msg_word,
    input  wire logic        i_first_block,
    input  wire logic        i_last_block,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [31:0]      o_digest_word,
    output logic [2:0]       o_digest_index,
    output logic             o_digest_last
);

    typedef enum logic [1:0] {
        S_GATHER,
        S_ROUND,
        S_FINAL,
        S_EMIT
    } t_state;

    localparam logic [3:0] LAST_WORD  = 4'(sbc_pkg::BLK_WORDS - 1);
    localparam logic [5:0] LAST_ROUND = 6'(sbc_pkg::ROUNDS - 1);
    localparam logic [2:0] LAST_IDX   = 3'(sbc_pkg::HASH_WORDS - 1);

    t_state          r_state, n_state;
    logic [3:0]      r_count, n_count;
    logic [5:0]      r_round, n_round;
    logic [2:0]      r_idx,   n_idx;
    logic            r_last,  n_last;
    sbc_pkg::t_word  r_chain [sbc_pkg::HASH_WORDS];
    sbc_pkg::t_word  n_chain [sbc_pkg::HASH_WORDS];
    sbc_pkg::t_word  r_w     [sbc_pkg::BLK_WORDS];
    sbc_pkg::t_word  n_w     [sbc_pkg::BLK_WORDS];
    sbc_pkg::t_word  r_v     [sbc_pkg::HASH_WORDS];
    sbc_pkg::t_word  n_v     [sbc_pkg::HASH_WORDS];

    logic            in_fire;
    logic            out_fire;
    sbc_pkg::t_word  w_next;
    sbc_pkg::t_word  t1;
    sbc_pkg::t_word  t2;

    // Input is open while gathering, and during digest output for all but the
    // word that would start the next compression.
    assign o_ready  = (r_state == S_GATHER) || (r_state == S_EMIT && r_count != LAST_WORD);
    assign in_fire  = i_valid && o_ready;
    assign o_valid  = (r_state == S_EMIT);
    assign out_fire = o_valid && i_ready;

    assign o_digest_word  = r_chain[r_idx];
    assign o_digest_index = r_idx;
    assign o_digest_last  = (r_idx == LAST_IDX);

    // Schedule expansion: window holds W[t..t+15]; produce W[t+16].
    assign w_next = sbc_pkg::sig_small1(r_w[14]) + r_w[9]
                  + sbc_pkg::sig_small0(r_w[1]) + r_w[0];

    // Round unit.
    assign t1 = r_v[7] + sbc_pkg::sig_big1(r_v[4]) + sbc_pkg::choose(r_v[4], r_v[5], r_v[6])
              + sbc_pkg::K_ROUND[r_round] + r_w[0];
    assign t2 = sbc_pkg::sig_big0(r_v[0]) + sbc_pkg::majority(r_v[0], r_v[1], r_v[2]);

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_round = r_round;
        n_idx   = r_idx;
        n_last  = r_last;
        n_chain = r_chain;
        n_w     = r_w;
        n_v     = r_v;

        // Word transaction: shift the word into the window.
        if (in_fire) begin
            for (int i = 0; i < sbc_pkg::BLK_WORDS - 1; i++) begin
                n_w[i] = r_w[i + 1];
            end
            n_w[sbc_pkg::BLK_WORDS - 1] = i_msg_word;
            n_count = r_count + 4'd1;
        end

        unique case (r_state)
            S_GATHER: begin
                if (in_fire && r_count == LAST_WORD) begin
                    n_count = '0;
                    n_last  = i_last_block;
                    n_round = '0;
                    n_state = S_ROUND;
                    if (i_first_block) begin
                        n_chain = sbc_pkg::H_INIT;
                        n_v     = sbc_pkg::H_INIT;
                    end else begin
                        n_v     = r_chain;
                    end
                end
            end
            S_ROUND: begin
                n_v[7] = r_v[6];
                n_v[6] = r_v[5];
                n_v[5] = r_v[4];
                n_v[4] = r_v[3] + t1;
                n_v[3] = r_v[2];
                n_v[2] = r_v[1];
                n_v[1] = r_v[0];
                n_v[0] = t1 + t2;
                for (int i = 0; i < sbc_pkg::BLK_WORDS - 1; i++) begin
                    n_w[i] = r_w[i + 1];
                end
                n_w[sbc_pkg::BLK_WORDS - 1] = w_next;
                n_round = r_round + 6'd1;
                if (r_round == LAST_ROUND) begin
                    n_state = S_FINAL;
                end
            end
            S_FINAL: begin
                for (int i = 0; i < sbc_pkg::HASH_WORDS; i++) begin
                    n_chain[i] = r_chain[i] + r_v[i];
                end
                n_idx   = '0;
                n_state = r_last ? S_EMIT : S_GATHER;
            end
            S_EMIT: begin
                if (out_fire) begin
                    n_idx = r_idx + 3'd1;
                    if (r_idx == LAST_IDX) begin
                        n_state = S_GATHER;
                    end
                end
            end
            default: n_state = S_GATHER;
        endcase
    end

    // Control state and chaining value.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_GATHER;
            r_count <= '0;
            r_round <= '0;
            r_idx   <= '0;
            r_last  <= 1'b0;
            r_chain <= sbc_pkg::H_INIT;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_round <= n_round;
            r_idx   <= n_idx;
            r_last  <= n_last;
            r_chain <= n_chain;
        end
    end

    // Schedule window and working variables.
    always_ff @(posedge i_clk) begin
        r_w <= n_w;
        r_v <= n_v;
    end

    // The word that starts a compression is taken only while gathering.
    a_start_only_gather: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && r_count == LAST_WORD) |-> (r_state == S_GATHER))
        else $error("sixteenth word taken outside gather");

    // No partial block is pending while the round unit runs.
    a_count_idle_rounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROUND || r_state == S_FINAL) |-> (r_count == '0))
        else $error("word count moved during compression");

    // The last round is followed by the chaining add.
    a_round_to_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROUND && r_round == LAST_ROUND) |=> (r_state == S_FINAL))
        else $error("round sequence did not end in chaining add");

    // A final block opens digest output at index zero.
    a_emit_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINAL && r_last) |=> (o_valid && o_digest_index == '0))
        else $error("digest output did not start at index zero");

    // Output closes after the marked last digest word.
    a_emit_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_fire && o_digest_last) |=> !o_valid)
        else $error("digest output continued past last word");

endmodule

`default_nettype wire

FILE: verif/sbc_checker.sv
// Digest predictor and scoreboard for the SHA-256 block compressor.
module sbc_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_ready,
    input  wire logic [31:0] i_msg_word,
    input  wire logic        i_first_block,
    input  wire logic        i_last_block,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_ready,
    input  wire logic [31:0] i_digest_word,
    input  wire logic [2:0]  i_digest_index,
    input  wire logic        i_digest_last,
    output int               o_fail_count,
    output int               o_pending
);

    typedef sbc_pkg::t_word t_word;

    typedef struct packed {
        t_word      word;
        logic [2:0] index;
        logic       last;
    } t_digest_entry;

    localparam t_word ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam t_word IV_WORDS [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    t_word         chain_value [8];
    t_word         block_words [16];
    logic [3:0]    words_gathered;
    t_digest_entry digest_queue [$];
    int            mismatches = 0;

    function automatic t_word ror(input t_word v, input int unsigned n);
        logic [63:0] doubled;
        doubled = {v, v} >> n;
        return doubled[31:0];
    endfunction

    // Expand the schedule in a rolling window of sixteen words and run all rounds.
    task automatic compress_gathered_block();
        t_word sched [16];
        t_word a, b, c, d, e, f, g, h;
        t_word wt, t1, t2, s0, s1;
        sched = block_words;
        a = chain_value[0]; b = chain_value[1]; c = chain_value[2]; d = chain_value[3];
        e = chain_value[4]; f = chain_value[5]; g = chain_value[6]; h = chain_value[7];
        for (int r = 0; r < 64; r++) begin
            if (r < 16) begin
                wt = sched[r];
            end else begin
                s0 = ror(sched[(r + 1) & 15], 7) ^ ror(sched[(r + 1) & 15], 18)
                   ^ (sched[(r + 1) & 15] >> 3);
                s1 = ror(sched[(r + 14) & 15], 17) ^ ror(sched[(r + 14) & 15], 19)
                   ^ (sched[(r + 14) & 15] >> 10);
                wt = s1 + sched[(r + 9) & 15] + s0 + sched[r & 15];
                sched[r & 15] = wt;
            end
            t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
               + ROUND_K[r] + wt;
            t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        chain_value[0] += a; chain_value[1] += b; chain_value[2] += c; chain_value[3] += d;
        chain_value[4] += e; chain_value[5] += f; chain_value[6] += g; chain_value[7] += h;
    endtask

    // Store the word; flags count only on the sixteenth word of a block.
    task automatic absorb_word(input t_word w, input logic first, input logic last);
        t_digest_entry entry;
        block_words[words_gathered] = w;
        if (words_gathered != 4'd15) begin
            words_gathered++;
        end else begin
            words_gathered = 4'd0;
            if (first) chain_value = IV_WORDS;
            compress_gathered_block();
            if (last) begin
                for (int i = 0; i < 8; i++) begin
                    entry.word  = chain_value[i];
                    entry.index = 3'(i);
                    entry.last  = (i == 7);
                    digest_queue = {digest_queue, entry};
                end
            end
        end
    endtask

    task automatic report(input string what, input t_digest_entry expd,
                          input t_digest_entry seen);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t: %s: expected %08h/%0d/%0b, got %08h/%0d/%0b",
                     $realtime, what, expd.word, expd.index, expd.last,
                     seen.word, seen.index, seen.last);
        end
    endtask

    always @(posedge i_clk) begin
        t_digest_entry seen;
        t_digest_entry expd;
        if (!i_rst_n) begin
            chain_value = IV_WORDS;
            foreach (block_words[i]) block_words[i] = '0;
            words_gathered = 4'd0;
            digest_queue.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                absorb_word(i_msg_word, i_first_block, i_last_block);
            end
            if (i_out_valid && i_out_ready) begin
                seen.word  = i_digest_word;
                seen.index = i_digest_index;
                seen.last  = i_digest_last;
                if (digest_queue.size() == 0) begin
                    expd = '0;
                    report("unexpected digest word", expd, seen);
                end else begin
                    expd = digest_queue.pop_front();
                    if (seen != expd) report("digest mismatch", expd, seen);
                end
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= digest_queue.size();
    end

endmodule

FILE: verif/tb.sv
// Top-level testbench for the SHA-256 block compressor: stimulus, handshake pressure, verdict.
module tb;

    // Cycles with no transaction on either channel before the run is declared hung.
    // The longest legitimate quiet stretch is the long output hold below plus one
    // compression pass, so this leaves ample margin.
    localparam int STALL_LIMIT      = 5000;
    // Length of the one long receiver hold-off, enough to back the block up into
    // its input side after a final block.
    localparam int LONG_HOLD        = 600;
    // Settle time after the last expected digest word: more than one full block.
    localparam int DRAIN_CYCLES     = 100;
    localparam int BLOCKS_PER_PHASE = 4;
    // A trailing partial block that must never produce a result.
    localparam int TAIL_WORDS       = 5;

    // Directed block: field extremes, walking patterns and alternating bits.
    localparam logic [31:0] CORNER_WORDS [16] = '{
        32'h00000000, 32'hffffffff, 32'h80000000, 32'h00000001,
        32'h7fffffff, 32'hfffffffe, 32'h55555555, 32'haaaaaaaa,
        32'hffffffff, 32'h00000000, 32'h0000ffff, 32'hffff0000,
        32'h80000001, 32'h7ffffffe, 32'hdeadbeef, 32'hffffffff
    };

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_valid       = 1'b0;
    logic [31:0] i_msg_word    = '0;
    logic        i_first_block = 1'b0;
    logic        i_last_block  = 1'b0;
    logic        i_ready       = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [31:0] o_digest_word;
    logic [2:0]  o_digest_index;
    logic        o_digest_last;

    int   fail_count;
    int   pending;
    int   tx_idle_pct  = 0;
    int   rx_stall_pct = 0;
    logic hold_request = 1'b0;
    logic hold_taken   = 1'b0;
    int   hold_left    = 0;
    int   idle_cycles  = 0;
    int   msg_block    = 0;
    int   msg_blocks   = 0;

    sha256_block_compress dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_msg_word     (i_msg_word),
        .i_first_block  (i_first_block),
        .i_last_block   (i_last_block),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_digest_word  (o_digest_word),
        .o_digest_index (o_digest_index),
        .o_digest_last  (o_digest_last)
    );

    sbc_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_valid),
        .i_in_ready     (o_ready),
        .i_msg_word     (i_msg_word),
        .i_first_block  (i_first_block),
        .i_last_block   (i_last_block),
        .i_out_valid    (o_valid),
        .i_out_ready    (i_ready),
        .i_digest_word  (o_digest_word),
        .i_digest_index (o_digest_index),
        .i_digest_last  (o_digest_last),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Digest receiver: take the one long hold-off when asked, otherwise stall at
    // the current phase's rate. The hold counts down here, independent of the
    // sender, so the sender keeps offering words while the output is blocked.
    always @(posedge i_clk) begin
        if (hold_request && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_left  <= LONG_HOLD;
            i_ready    <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_ready   <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Watchdog: count cycles with no transaction on either channel.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
    end

    initial begin
        while (idle_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("sha256_block_compress regression: fail");
        $finish;
    end

    // Mostly uniform words, with a share of all-zero, all-one and single-bit
    // patterns so the adders see carries from the extremes.
    function automatic logic [31:0] pick_word();
        int unsigned bit_pos;
        bit_pos = $urandom_range(31);
        case ($urandom_range(15))
            0:       return 32'h00000000;
            1:       return 32'hffffffff;
            2:       return 32'h1 << bit_pos;
            3:       return ~(32'h1 << bit_pos);
            default: return $urandom();
        endcase
    endfunction

    // Offer one word transaction; idle first at the phase's rate, then hold
    // valid and payload steady until the block accepts.
    task automatic send_word(input logic [31:0] w, input logic first, input logic last);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_msg_word    <= w;
        i_first_block <= first;
        i_last_block  <= last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    // Advance at least one edge so the checker's count covers the latest
    // transaction, then hold until no digest word is outstanding.
    task automatic wait_drained();
        do @(posedge i_clk); while (pending != 0);
    endtask

    // One idling setting: stream whole blocks grouped into messages of one to
    // three blocks, then pause the sender until every digest word is back.
    task automatic run_phase(input int idle_pct, input int stall_pct);
        logic first;
        logic last;
        tx_idle_pct  = idle_pct;
        rx_stall_pct <= stall_pct;
        for (int blk = 0; blk < BLOCKS_PER_PHASE; blk++) begin
            if (msg_block >= msg_blocks) begin
                msg_blocks = $urandom_range(1, 3);
                msg_block  = 0;
            end
            first = (msg_block == 0);
            last  = (msg_block == msg_blocks - 1);
            // Drop in malformed messages now and then: missing start, repeated
            // start, early or missing end.
            if ($urandom_range(99) < 15) begin
                first = 1'($urandom_range(1));
                last  = 1'($urandom_range(1));
            end
            msg_block++;
            // Flags on the first fifteen words are ignored by the block; toggle them freely.
            for (int k = 0; k < 15; k++) begin
                send_word(pick_word(), 1'($urandom_range(1)), 1'($urandom_range(1)));
            end
            send_word(pick_word(), first, last);
        end
        wait_drained();
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n      <= 1'b1;
        // Block the output right away: the directed digest backs up, the next
        // block's first fifteen words go in, and its sixteenth must wait.
        hold_request <= 1'b1;

        // Directed block: ignored flags toggle on the first fifteen words; the
        // sixteenth ends a message that never set first_block, so the reset
        // chaining value must carry on.
        for (int k = 0; k < 16; k++) begin
            if (k < 15) send_word(CORNER_WORDS[k], k[0], k[1]);
            else send_word(CORNER_WORDS[k], 1'b0, 1'b1);
        end

        run_phase(0, 0);
        run_phase(51, 0);
        run_phase(0, 51);
        run_phase(10, 10);

        // Leave a block unfinished; it must stay silent.
        for (int k = 0; k < TAIL_WORDS; k++) begin
            send_word(pick_word(), 1'($urandom_range(1)), 1'($urandom_range(1)));
        end
        i_valid <= 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("sha256_block_compress regression: pass");
        end else begin
            $display("sha256_block_compress regression: fail");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/sbc_pkg.sv
rtl/sha256_block_compress.sv
verif/sbc_checker.sv
verif/tb.sv
